// ===== design/aes_ctr_keystream_cipher_core_assert.svh =====
// Assertion macros shared by the cipher core RTL.
`ifndef AES_CTR_KEYSTREAM_CIPHER_CORE_ASSERT_SVH
`define AES_CTR_KEYSTREAM_CIPHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");
`define AES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");
`else
`define AES_ASSERT_IMP(lbl, ante, cons)
`define AES_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/aes_ctr_pkg.sv =====
// Package with shared types, constants and AES byte functions.
package aes_ctr_pkg;

    localparam int MAX_ROUNDS_DEF = 14;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CTR = 3'd5;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] XT_POLY   = 8'h1b;

    typedef struct packed {
        logic [127:0] blk;
        logic [127:0] data;
        logic [15:0]  mask;
        logic [4:0]   count;
    } item_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] nr;
    } key_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? XT_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] sbox_byte(input logic [7:0] x);
        sbox_byte = SBOX[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox_byte(w[31:24]), sbox_byte(w[23:16]),
                    sbox_byte(w[15:8]), sbox_byte(w[7:0])};
    endfunction

endpackage

// ===== design/aes_ctr_front.sv =====
// Front end: accepts input transactions, builds counter blocks and byte masks.
module aes_ctr_front
    import aes_ctr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           data_high,
    input  logic [63:0]           data_low,
    input  logic [4:0]            byte_count,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  key_busy,
    input  logic                  q_full,
    output logic                  push,
    output item_t                 push_item
);

    logic [63:0] counter_reg;
    logic [63:0] counter_next;
    logic [4:0]  used;

    assign in_stall = key_busy | q_full;
    assign push     = in_valid & ~in_stall;
    assign used     = (byte_count > 5'd16) ? 5'd16 : byte_count;

    always_comb
    begin
        push_item.blk   = {64'd0, counter_reg};
        push_item.data  = {data_high, data_low};
        push_item.count = byte_count;
        for (int j = 0; j < 16; j++)
        begin
            push_item.mask[15-j] = (5'(j) < used);
        end
        counter_next = counter_reg;
        if (cfg_write_en && cfg_index == CFG_START_CTR)
        begin
            counter_next = cfg_data;
        end
        else if (push && used != 5'd0)
        begin
            counter_next = counter_reg + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= 64'd0;
        end
        else
        begin
            counter_reg <= counter_next;
        end
    end

endmodule

// ===== design/aes_ctr_fifo.sv =====
// Two-entry queue between the front end and the round pipeline.
module aes_ctr_fifo
    import aes_ctr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/aes_ctr_keyexp.sv =====
// Key registers and the one-word-per-cycle round key expansion.
module aes_ctr_keyexp
    import aes_ctr_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
    localparam int KEY_WORDS = 4 * (MAX_ROUNDS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output key_status_t           status,
    output logic [31:0]           round_keys [KEY_WORDS]
);

    localparam int IDX_W = $clog2(KEY_WORDS);

    logic [1:0]       key_size_reg;
    logic [63:0]      key_reg [4];
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [2:0]       pos_reg;
    logic [7:0]       rcon_reg;
    logic [31:0]      win_reg [8];
    logic [31:0]      store_reg [KEY_WORDS];

    logic [1:0]       sel;
    logic [3:0]       nk;
    logic [3:0]       nr;
    logic [IDX_W-1:0] last_idx;
    logic             key_phase;
    logic [31:0]      key_word;
    logic [31:0]      far_word;
    logic [31:0]      tmp;
    logic [31:0]      new_word;
    logic             key_write;

    assign key_write = cfg_write_en && (cfg_index <= CFG_KEY_D);

    always_comb
    begin
        sel = (key_size_reg == 2'd3) ? 2'd2 : key_size_reg;
        nk  = 4'd4 + {1'b0, sel, 1'b0};
        nr  = 4'd10 + {1'b0, sel, 1'b0};
        if (nr > 4'(MAX_ROUNDS))
        begin
            nr = 4'(MAX_ROUNDS);
        end
        last_idx  = IDX_W'(4 * int'(nr) + 3);
        key_phase = ({{(8-IDX_W){1'b0}}, idx_reg} < {4'd0, nk}) | (IDX_W > 8);
        key_word  = idx_reg[0] ? key_reg[idx_reg[2:1]][31:0] : key_reg[idx_reg[2:1]][63:32];
        case (nk)
            4'd4:    far_word = win_reg[3];
            4'd6:    far_word = win_reg[5];
            default: far_word = win_reg[7];
        endcase
        tmp = win_reg[0];
        if (pos_reg == 3'd0)
        begin
            tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_reg, 24'd0};
        end
        else if (nk == 4'd8 && pos_reg == 3'd4)
        begin
            tmp = sub_word(tmp);
        end
        new_word = key_phase ? key_word : (far_word ^ tmp);
    end

    assign status.busy = busy_reg;
    assign status.nr   = nr;

    always_comb
    begin
        for (int k = 0; k < KEY_WORDS; k++)
        begin
            round_keys[k] = store_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            store_reg[idx_reg] <= new_word;
            win_reg[0] <= new_word;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= 2'd0;
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= 64'd0;
            end
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            pos_reg  <= 3'd0;
            rcon_reg <= RCON_INIT;
        end
        else if (key_write)
        begin
            if (cfg_index == CFG_KEY_SIZE)
            begin
                key_size_reg <= cfg_data[1:0];
            end
            else
            begin
                key_reg[2'(cfg_index - CFG_KEY_A)] <= cfg_data;
            end
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            pos_reg  <= 3'd0;
            rcon_reg <= RCON_INIT;
        end
        else if (busy_reg)
        begin
            pos_reg <= ({1'b0, pos_reg} == nk - 4'd1) ? 3'd0 : pos_reg + 3'd1;
            if (!key_phase && pos_reg == 3'd0)
            begin
                rcon_reg <= xtime(rcon_reg);
            end
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == last_idx)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/aes_ctr_round.sv =====
// One registered AES round cell of the keystream pipeline.
module aes_ctr_round
    import aes_ctr_pkg::*;
#(
    parameter int ROUND = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  item_t        in_item,
    input  logic [127:0] rk,
    input  logic [3:0]   nr,
    output logic         out_valid,
    output item_t        out_item
);

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(4*c+r) -: 8] = sbox_byte(s[127-8*(4*((c+r)%4)+r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] s;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[127-32*c -: 8];
            a1 = t[119-32*c -: 8];
            a2 = t[111-32*c -: 8];
            a3 = t[103-32*c -: 8];
            s[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            s[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            s[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            s[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return s;
    endfunction

    logic         valid_reg;
    item_t        item_reg;
    logic [127:0] ss;
    logic [127:0] st;

    always_comb
    begin
        ss = sub_shift(in_item.blk);
        if (ROUND == 0)
        begin
            st = in_item.blk ^ rk;
        end
        else if (4'(ROUND) > nr)
        begin
            st = in_item.blk;
        end
        else if (4'(ROUND) == nr)
        begin
            st = ss ^ rk;
        end
        else
        begin
            st = mix_columns(ss) ^ rk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg.blk   <= st;
            item_reg.data  <= in_item.data;
            item_reg.mask  <= in_item.mask;
            item_reg.count <= in_item.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/aes_ctr_keystream_cipher_core.sv =====
// A result passes through the queue, the round cells and the output register after
// its input is accepted, and is held there until it is taken.
// Throughput: one block per cycle through the fully unrolled round pipeline, while
// no result is held by out_stall. After reset or any key register write, input
// stalls while the key schedule is expanded one word per cycle.
// Reset (asynchronous, active low) zeroes the counter and key registers and starts expansion.
`include "aes_ctr_keystream_cipher_core_assert.svh"
module aes_ctr_keystream_cipher_core
    import aes_ctr_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           data_high,
    input  logic [63:0]           data_low,
    input  logic [4:0]            byte_count,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [63:0]           result_high,
    output logic [63:0]           result_low,
    output logic [4:0]            valid_bytes
);

    localparam int KEY_WORDS = 4 * (MAX_ROUNDS + 1);
    localparam int STAGES    = MAX_ROUNDS + 1;

    // The front end builds a transaction with the counter block, the data
    // and a byte mask, and pushes it into a short queue.  The back end is a
    // chain of round cells, one per round key, with a global advance enable
    // that drops only while the output register holds an untaken result.
    key_status_t  key_status;
    logic [31:0]  round_keys [KEY_WORDS];
    logic         q_full;
    logic         q_push;
    item_t        q_push_item;
    logic         q_valid;
    item_t        q_head;
    logic         pipe_en;
    logic         stg_valid [STAGES+1];
    item_t        stg_item  [STAGES+1];

    logic         out_valid_reg;
    logic [127:0] result_reg;
    logic [4:0]   count_reg;
    logic [127:0] byte_mask;

    assign pipe_en = ~(out_valid_reg & out_stall);

    aes_ctr_keyexp #(.MAX_ROUNDS(MAX_ROUNDS)) u_keyexp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (key_status),
        .round_keys   (round_keys)
    );

    aes_ctr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_high    (data_high),
        .data_low     (data_low),
        .byte_count   (byte_count),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_busy     (key_status.busy),
        .q_full       (q_full),
        .push         (q_push),
        .push_item    (q_push_item)
    );

    aes_ctr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .pop        (pipe_en & q_valid),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    assign stg_valid[0] = q_valid;
    assign stg_item[0]  = q_head;

    // Cell r adds round key r; cells beyond the active round count pass the
    // state through, so every key size sees the same latency.
    for (genvar r = 0; r < STAGES; r++)
    begin : g_round
        aes_ctr_round #(.ROUND(r)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (stg_valid[r]),
            .in_item   (stg_item[r]),
            .rk        ({round_keys[4*r], round_keys[4*r+1],
                         round_keys[4*r+2], round_keys[4*r+3]}),
            .nr        (key_status.nr),
            .out_valid (stg_valid[r+1]),
            .out_item  (stg_item[r+1])
        );
    end

    // Bytes past the count come out as zero.
    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            byte_mask[127-8*j -: 8] = {8{stg_item[STAGES].mask[15-j]}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            result_reg <= (stg_item[STAGES].data ^ stg_item[STAGES].blk) & byte_mask;
            count_reg  <= stg_item[STAGES].count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= stg_valid[STAGES];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = result_reg[127:64];
    assign result_low  = result_reg[63:0];
    assign valid_bytes = count_reg;

    // No transaction may enter while the key schedule is being rebuilt.
    `AES_ASSERT_IMP(a_no_accept_busy, key_status.busy, in_stall)
    // A held result keeps its valid and byte count until it is taken.
    `AES_ASSERT_NXT(a_out_hold, out_valid_reg && out_stall,
        out_valid_reg && $stable(count_reg))
    // The queue head is kept while the pipeline is frozen.
    `AES_ASSERT_NXT(a_queue_hold, q_valid && !pipe_en, q_valid)

endmodule

// ===== bench/tb_aes_ctr_keystream_cipher_core.sv =====
// Self-checking testbench for the AES counter-mode keystream cipher core.
module tb_aes_ctr_keystream_cipher_core;
    import aes_ctr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes of the configuration port, written by name below.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE  = CFG_KEY_SIZE;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A     = CFG_KEY_A;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_D     = CFG_KEY_D;
    localparam logic [CFG_IDX_W-1:0] REG_START_CTR = CFG_START_CTR;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7  = 3'd7;

    // Key size select codes; the top code behaves like the 256-bit key.
    localparam logic [1:0] KEY_128  = 2'd0;
    localparam logic [1:0] KEY_192  = 2'd1;
    localparam logic [1:0] KEY_256  = 2'd2;
    localparam logic [1:0] KEY_ALT3 = 2'd3;

    localparam int ROUND_CAP     = 14;
    localparam int KEY_WORDS     = 4 * (ROUND_CAP + 1);
    localparam int DRAIN_CYCLES  = ROUND_CAP + 10;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int HOLD_OFF_LONG = 250;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [63:0]           data_high;
    logic [63:0]           data_low;
    logic [4:0]            byte_count;
    logic                  out_valid;
    logic                  out_stall;
    logic [63:0]           result_high;
    logic [63:0]           result_low;
    logic [4:0]            valid_bytes;

    aes_ctr_keystream_cipher_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_high    (data_high),
        .data_low     (data_low),
        .byte_count   (byte_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_high  (result_high),
        .result_low   (result_low),
        .valid_bytes  (valid_bytes)
    );

    typedef struct {
        logic [63:0] high;
        logic [63:0] low;
        logic [4:0]  count;
    } cipher_result_t;

    // Results that the shadow cipher has predicted and the core still owes.
    cipher_result_t pending_results[$];

    // Shadow copy of the core's configuration and state.
    logic [1:0]  shadow_key_size;
    logic [63:0] shadow_key[4];
    logic [63:0] shadow_counter;
    logic [31:0] round_keys[KEY_WORDS];
    bit          round_keys_stale;
    int          shadow_rounds;
    logic [7:0]  sub_table[256];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_cycles;
    int blocks_sent;
    int results_checked;
    int error_count;
    int quiet_cycles;

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            x = gf_double(x);
        end
        return acc;
    endfunction

    // The substitution byte is the field inverse followed by the affine map.
    function automatic logic [7:0] compute_sub_byte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] p;
        inv = 8'h01;
        p = x;
        for (int e = 254; e != 0; e = e >> 1)
        begin
            if (e & 1)
                inv = gf_mul(inv, p);
            p = gf_mul(p, p);
        end
        if (x == 8'h00)
            inv = 8'h00;
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub_key_word(input logic [31:0] w);
        return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
    endfunction

    function automatic void expand_round_keys();
        int sel;
        int nk;
        logic [255:0] key_bits;
        logic [31:0]  t;
        logic [7:0]   rcon;
        sel = (shadow_key_size == KEY_ALT3) ? 2 : int'(shadow_key_size);
        nk = 4 + 2 * sel;
        shadow_rounds = 10 + 2 * sel;
        key_bits = {shadow_key[0], shadow_key[1], shadow_key[2], shadow_key[3]};
        for (int i = 0; i < 4 * (shadow_rounds + 1); i++)
        begin
            if (i < nk)
                round_keys[i] = key_bits[255 - 32 * i -: 32];
            else
            begin
                t = round_keys[i - 1];
                if (i % nk == 0)
                begin
                    rcon = 8'h01;
                    for (int n = 1; n < i / nk; n++)
                        rcon = gf_double(rcon);
                    t = sub_key_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                end
                else if (nk == 8 && i % nk == 4)
                    t = sub_key_word(t);
                round_keys[i] = round_keys[i - nk] ^ t;
            end
        end
        round_keys_stale = 1'b0;
    endfunction

    function automatic void mix_in_round_key(ref logic [7:0] s[16], input int round);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4 * c + r] ^= round_keys[4 * round + c][31 - 8 * r -: 8];
    endfunction

    // Encrypts the counter block and returns the keystream, byte 0 on top.
    function automatic logic [127:0] keystream_for_counter(input logic [63:0] ctr);
        logic [7:0]   s[16];
        logic [7:0]   t[16];
        logic [127:0] ks;
        for (int j = 0; j < 16; j++)
            s[j] = (j < 8) ? 8'h00 : ctr[63 - 8 * (j - 8) -: 8];
        mix_in_round_key(s, 0);
        for (int round = 1; round <= shadow_rounds; round++)
        begin
            for (int j = 0; j < 16; j++)
                s[j] = sub_table[s[j]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4 * c + r] = s[4 * ((c + r) % 4) + r];
            if (round != shadow_rounds)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    s[4*c]   = gf_double(t[4*c]) ^ gf_double(t[4*c+1]) ^ t[4*c+1]
                               ^ t[4*c+2] ^ t[4*c+3];
                    s[4*c+1] = t[4*c] ^ gf_double(t[4*c+1]) ^ gf_double(t[4*c+2])
                               ^ t[4*c+2] ^ t[4*c+3];
                    s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_double(t[4*c+2])
                               ^ gf_double(t[4*c+3]) ^ t[4*c+3];
                    s[4*c+3] = gf_double(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                               ^ gf_double(t[4*c+3]);
                end
            end
            else
                s = t;
            mix_in_round_key(s, round);
        end
        for (int j = 0; j < 16; j++)
            ks[127 - 8 * j -: 8] = s[j];
        return ks;
    endfunction

    // Predicts the result of one accepted block and advances the shadow counter if it has bytes.
    function automatic cipher_result_t predict_block(input logic [63:0] hi, input logic [63:0] lo,
                                                     input logic [4:0] cnt);
        cipher_result_t res;
        logic [127:0] data;
        logic [127:0] ks;
        int used;
        if (round_keys_stale)
            expand_round_keys();
        used = (cnt > 16) ? 16 : int'(cnt);
        data = 128'h0;
        if (used > 0)
        begin
            ks = keystream_for_counter(shadow_counter) ^ {hi, lo};
            for (int j = 0; j < used; j++)
                data[127 - 8 * j -: 8] = ks[127 - 8 * j -: 8];
            shadow_counter = shadow_counter + 64'd1;
        end
        res.high = data[127:64];
        res.low = data[63:0];
        res.count = cnt;
        return res;
    endfunction

    // Writes one register; callers make sure the core is idle first.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_KEY_SIZE:
            begin
                shadow_key_size = value[1:0];
                round_keys_stale = 1'b1;
            end
            REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D:
            begin
                shadow_key[idx - REG_KEY_A] = value;
                round_keys_stale = 1'b1;
            end
            REG_START_CTR:
                shadow_counter = value;
            default:
                ;
        endcase
    endtask

    // Waits until every predicted result has arrived and the pipeline has drained.
    task automatic drain_pipeline();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_key(input logic [1:0] size, input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c, input logic [63:0] d, input logic [63:0] ctr);
        drain_pipeline();
        write_register(REG_KEY_SIZE, {62'h0, size});
        write_register(REG_KEY_A, a);
        write_register(REG_KEY_B, b);
        write_register(REG_KEY_C, c);
        write_register(REG_KEY_D, d);
        write_register(REG_START_CTR, ctr);
    endtask

    // Offers one block and holds it until the core accepts the transaction.
    // The valid stays high afterwards unless the idle gap lowers it.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic [4:0] cnt);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        data_high <= hi;
        data_low <= lo;
        byte_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_block(hi, lo, cnt));
        blocks_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic release_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [4:0] random_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return 5'd16;
        if (pick < 93)
            return 5'($urandom_range(15, 1));
        if (pick < 96)
            return 5'd0;
        return 5'($urandom_range(31, 17));
    endfunction

    task automatic send_random_blocks(input int n);
        for (int i = 0; i < n; i++)
            send_block({$urandom, $urandom}, {$urandom, $urandom}, random_count());
        release_valid();
    endtask

    task automatic load_random_key();
        load_key(2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // Reset keys and the reset counter: the first block waits for the key expansion that reset starts.
    task automatic test_reset_state();
        send_block(64'h0, 64'h0, 5'd16);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd16);
        release_valid();
    endtask

    // Each key size with a fixed key (all-zero for 256 bits, all-one for the alias of the top select code).
    task automatic test_key_sizes();
        logic [63:0] ones;
        ones = 64'hffff_ffff_ffff_ffff;
        load_key(KEY_128, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, ones, ones, 64'h0);
        send_block(64'h0, 64'h0, 5'd16);
        release_valid();
        load_key(KEY_192, ones, ones, ones, 64'h0, 64'h1);
        send_block(64'h0, 64'h0, 5'd16);
        send_block(ones, ones, 5'd16);
        release_valid();
        load_key(KEY_256, 64'h0, 64'h0, 64'h0, 64'h0, ones >> 1);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd16);
        release_valid();
        load_key(KEY_ALT3, ones, ones, ones, ones, 64'h8000_0000_0000_0000);
        send_block(ones, 64'h0, 5'd16);
        release_valid();
    endtask

    // Counter wrap, several short counts, the zero count and counts above sixteen.
    task automatic test_counts_and_wrap();
        load_key(KEY_128, 64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c, 64'h0, 64'h0,
                 64'hffff_ffff_ffff_fffe);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd16);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd1);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd0);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd15);
        send_block(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 5'd8);
        send_block(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 5'd9);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd17);
        send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd31);
        release_valid();
        // Writes to indexes past the register list must change nothing.
        drain_pipeline();
        write_register(REG_UNUSED_6, 64'hffff_ffff_ffff_ffff);
        write_register(REG_UNUSED_7, 64'hffff_ffff_ffff_ffff);
        send_block(64'h0, 64'h0, 5'd16);
        send_block(64'h0, 64'h0, 5'd4);
        release_valid();
    endtask

    // Random traffic under each idling pattern, with a fresh key per chunk.
    task automatic test_random_traffic();
        int idle_mix[4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{7, 7}};
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_mix[phase][0];
            receiver_stall_pct = idle_mix[phase][1];
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                load_random_key();
                send_random_blocks(120);
            end
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        load_random_key();
        hold_off_cycles = HOLD_OFF_LONG;
        send_random_blocks(70);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Checks every result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        cipher_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: result_high %h result_low %h",
                       result_high, result_low);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result_high !== want.high)
                begin
                    $error("result_high expected %h actual %h", want.high, result_high);
                    error_count++;
                end
                if (result_low !== want.low)
                begin
                    $error("result_low expected %h actual %h", want.low, result_low);
                    error_count++;
                end
                if (valid_bytes !== want.count)
                begin
                    $error("valid_bytes expected %0d actual %0d", want.count, valid_bytes);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_high = '0;
        data_low = '0;
        byte_count = '0;
        out_stall = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        blocks_sent = 0;
        results_checked = 0;
        error_count = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 256; i++)
            sub_table[i] = compute_sub_byte(8'(i));
        // Shadow state matches the core after reset.
        shadow_key_size = KEY_128;
        for (int i = 0; i < 4; i++)
            shadow_key[i] = 64'h0;
        shadow_counter = 64'h0;
        round_keys_stale = 1'b1;
        shadow_rounds = 10;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_key_sizes();
        test_counts_and_wrap();
        test_random_traffic();
        test_backpressure();
        drain_pipeline();

        $display("Sent %0d blocks and checked %0d results over all key sizes,", blocks_sent,
                 results_checked);
        $display("short and oversized counts, counter wrap, idling and a long output hold-off.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
